// ===== rtl/core/gcc_pkg.sv =====
// Shared types, constants, denomination table and microcode ROM for the
// greedy coin change core. No dependencies.
`default_nettype none

package gcc_pkg;

    localparam int AMOUNT_W    = 24;
    localparam int INDEX_W     = 4;
    localparam int CENTS_W     = 16;
    localparam int COUNT_W     = 21;
    localparam int TABLE_SLOTS = 16;
    localparam int NUM_DENOMS_DEF = 15;

    localparam int DIVIDEND_W = AMOUNT_W + 1;
    localparam int STEP_W     = 5;
    localparam int PC_W       = 4;

    typedef logic [AMOUNT_W-1:0]   t_amount;
    typedef logic [INDEX_W-1:0]    t_index;
    typedef logic [CENTS_W-1:0]    t_cents;
    typedef logic [COUNT_W-1:0]    t_count;
    typedef logic [DIVIDEND_W-1:0] t_dividend;
    typedef logic [STEP_W-1:0]     t_step;
    typedef logic [PC_W-1:0]       t_pc;

    localparam t_dividend ROUND_BIAS = t_dividend'(5);
    localparam int ROUND_SHIFT = 28;
    localparam t_dividend ROUND_RECIP = t_dividend'(((1 << ROUND_SHIFT) + 9) / 10);
    localparam t_step DENOM_STEPS_M1 = t_step'(COUNT_W - 1);
    localparam int DENOM_PAD = DIVIDEND_W - COUNT_W;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_DSTEP,
        OP_SETREM,
        OP_LOAD_DIV,
        OP_EMIT,
        OP_DEC_K
    } t_uop;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_NO_INPUT,
        C_CNT_NZ,
        C_REM_ZERO,
        C_SKIP,
        C_OUT_BUSY,
        C_DONE
    } t_ucond;

    typedef struct packed {
        t_uop   op;
        t_ucond cond;
        t_pc    target;
    } t_uword;

    typedef struct packed {
        logic load;
        logic step;
    } t_div_ctrl;

    typedef struct packed {
        logic cnt_nz;
    } t_div_stat;

    localparam t_pc PC_IDLE       = t_pc'(0);
    localparam t_pc PC_SETREM     = t_pc'(1);
    localparam t_pc PC_TEST       = t_pc'(2);
    localparam t_pc PC_SELECT     = t_pc'(3);
    localparam t_pc PC_DIV_DENOM  = t_pc'(4);
    localparam t_pc PC_EMIT       = t_pc'(5);
    localparam t_pc PC_NEXT       = t_pc'(6);
    localparam t_pc PC_DEC        = t_pc'(7);

    function automatic t_cents denom_value(input t_index idx);
        t_cents v;
        unique case (idx)
            4'd0:    v = t_cents'(1);
            4'd1:    v = t_cents'(2);
            4'd2:    v = t_cents'(5);
            4'd3:    v = t_cents'(10);
            4'd4:    v = t_cents'(20);
            4'd5:    v = t_cents'(50);
            4'd6:    v = t_cents'(100);
            4'd7:    v = t_cents'(200);
            4'd8:    v = t_cents'(500);
            4'd9:    v = t_cents'(1000);
            4'd10:   v = t_cents'(2000);
            4'd11:   v = t_cents'(5000);
            4'd12:   v = t_cents'(10000);
            4'd13:   v = t_cents'(20000);
            4'd14:   v = t_cents'(50000);
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        unique case (pc)
            PC_IDLE:      w = '{OP_ACCEPT,   C_NO_INPUT, PC_IDLE};
            PC_SETREM:    w = '{OP_SETREM,   C_ALWAYS,   PC_TEST};
            PC_TEST:      w = '{OP_NONE,     C_REM_ZERO, PC_IDLE};
            PC_SELECT:    w = '{OP_LOAD_DIV, C_SKIP,     PC_NEXT};
            PC_DIV_DENOM: w = '{OP_DSTEP,    C_CNT_NZ,   PC_DIV_DENOM};
            PC_EMIT:      w = '{OP_EMIT,     C_OUT_BUSY, PC_EMIT};
            PC_NEXT:      w = '{OP_NONE,     C_DONE,     PC_IDLE};
            PC_DEC:       w = '{OP_DEC_K,    C_ALWAYS,   PC_SELECT};
            default:      w = '{OP_NONE,     C_ALWAYS,   PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gcc_req_if.sv =====
// Request channel: one amount per transfer.
// Depends on gcc_pkg.
`default_nettype none

interface gcc_req_if
    import gcc_pkg::*;
;
    logic    valid;
    logic    ready;
    t_amount amount_milli;

    modport source (output valid, output amount_milli, input ready);
    modport sink   (input valid, input amount_milli, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/gcc_res_if.sv =====
// Result channel: one denomination entry per transfer.
// Depends on gcc_pkg.
`default_nettype none

interface gcc_res_if
    import gcc_pkg::*;
;
    logic   valid;
    logic   ready;
    t_index denom_index;
    t_cents denom_cents;
    t_count piece_count;
    logic   last;

    modport source (output valid, output denom_index, output denom_cents,
                    output piece_count, output last, input ready);
    modport sink   (input valid, input denom_index, input denom_cents,
                    input piece_count, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/greedy_coin_change_core.sv =====
// Greedy coin change core: microcoded sequencer over a serial divider.
// Depends on gcc_pkg, gcc_req_if, gcc_res_if and gcc_divider.
//
// Usage:
//   i_req carries one amount in thousandths of a euro per transfer. The
//   amount is rounded half-up to cents, then split over the denomination
//   table from the largest value down. o_res carries one entry per
//   denomination used (index, value in cents, piece count); the entry that
//   clears the remainder has last set. An amount below 5 gives no entry.
//   i_req.ready is high only while the sequencer is idle; one amount is
//   worked at a time.
//   Steps: the amount is taken, rounded by reciprocal multiplication and
//   tested for zero; then each denomination, from the largest down, is
//   either skipped or divided by the serial divider and its entry emitted.
//   o_res is a single output register: the sequencer holds at the emit step
//   while a previous entry has not been transferred, and a stall on o_res
//   stretches the work of the current amount by the stalled cycles.
//   Reset (synchronous, active low) returns the sequencer to idle and drops
//   any pending result.
`default_nettype none

module greedy_coin_change_core
    import gcc_pkg::*;
#(
    parameter int NUM_DENOMS = NUM_DENOMS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    gcc_req_if.sink     i_req,
    gcc_res_if.source   o_res
);

    localparam t_index TOP_INDEX =
        t_index'((NUM_DENOMS > TABLE_SLOTS) ? TABLE_SLOTS - 1 : NUM_DENOMS - 1);

    t_pc        r_pc;
    t_pc        n_pc;
    t_count     r_remain;
    t_index     r_k;
    logic       r_out_valid;
    t_index     r_out_index;
    t_cents     r_out_cents;
    t_count     r_out_count;
    logic       r_out_last;

    t_uword     w_uword;
    t_cents     w_value;
    logic       w_skip;
    logic       w_out_free;
    logic       w_cond;
    logic       w_accept;
    logic       w_emit;
    t_div_ctrl  w_div_ctrl;
    t_div_stat  w_div_stat;
    t_dividend  w_dividend;
    t_step      w_count;
    t_cents     w_divisor;
    t_dividend  w_quotient;
    t_cents     w_remainder;
    logic [2*DIVIDEND_W-1:0] w_round_prod;

    assign w_uword    = ucode(r_pc);
    assign w_value    = denom_value(r_k);
    assign w_skip     = (w_value == '0) || (COUNT_W'(w_value) > r_remain);
    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_accept   = (w_uword.op == OP_ACCEPT) && i_req.valid;
    assign w_emit     = (w_uword.op == OP_EMIT) && w_out_free;

    assign i_req.ready = (w_uword.op == OP_ACCEPT);

    always_comb begin
        w_div_ctrl.load = 1'b0;
        w_div_ctrl.step = 1'b0;
        w_dividend      = {r_remain, {DENOM_PAD{1'b0}}};
        w_divisor       = w_value;
        w_count         = DENOM_STEPS_M1;
        unique case (w_uword.op)
            OP_ACCEPT: begin
                w_div_ctrl.load = i_req.valid;
                w_dividend      = {1'b0, i_req.amount_milli} + ROUND_BIAS;
            end
            OP_LOAD_DIV: w_div_ctrl.load = 1'b1;
            OP_DSTEP:    w_div_ctrl.step = 1'b1;
            default: begin
            end
        endcase
    end

    gcc_divider u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_div_ctrl),
        .i_dividend  (w_dividend),
        .i_divisor   (w_divisor),
        .i_count     (w_count),
        .o_quotient  (w_quotient),
        .o_remainder (w_remainder),
        .o_stat      (w_div_stat)
    );

    assign w_round_prod = w_quotient * ROUND_RECIP;

    always_comb begin
        unique case (w_uword.cond)
            C_ALWAYS:   w_cond = 1'b1;
            C_NO_INPUT: w_cond = !i_req.valid;
            C_CNT_NZ:   w_cond = w_div_stat.cnt_nz;
            C_REM_ZERO: w_cond = (r_remain == '0);
            C_SKIP:     w_cond = w_skip;
            C_OUT_BUSY: w_cond = !w_out_free;
            C_DONE:     w_cond = (r_remain == '0) || (r_k == '0);
            default:    w_cond = 1'b1;
        endcase
        n_pc = w_cond ? w_uword.target : r_pc + t_pc'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_uword.op == OP_SETREM) begin
            r_remain <= w_round_prod[ROUND_SHIFT +: COUNT_W];
            r_k      <= TOP_INDEX;
        end else if (w_emit) begin
            r_remain <= COUNT_W'(w_remainder);
        end else if (w_uword.op == OP_DEC_K) begin
            r_k <= r_k - t_index'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_index <= r_k;
            r_out_cents <= w_value;
            r_out_count <= w_quotient[COUNT_W-1:0];
            r_out_last  <= (w_remainder == '0);
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.denom_index = r_out_index;
    assign o_res.denom_cents = r_out_cents;
    assign o_res.piece_count = r_out_count;
    assign o_res.last        = r_out_last;

`ifndef SYNTHESIS
    a_accept_starts_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_pc == PC_SETREM)
        else $error("accepted amount did not start rounding");

    a_select_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc == PC_SELECT |-> r_remain != '0)
        else $error("denomination selected with zero remainder");

    a_pieces_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> w_quotient[COUNT_W-1:0] != '0)
        else $error("entry emitted with zero pieces");

    a_pc_in_program: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc <= PC_DEC)
        else $error("sequencer left the program");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/gcc_divider.sv =====
// Restoring serial divider, one quotient bit per cycle while stepped, for the
// per-denomination division; its dividend register also holds the biased amount
// for rounding. Depends on gcc_pkg.
`default_nettype none

module gcc_divider
    import gcc_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  t_div_ctrl  i_ctrl,
    input  t_dividend  i_dividend,
    input  t_cents     i_divisor,
    input  t_step      i_count,
    output t_dividend  o_quotient,
    output t_cents     o_remainder,
    output t_div_stat  o_stat
);

    t_step           r_cnt;
    t_dividend       r_q;
    t_cents          r_p;
    t_cents          r_d;
    logic [CENTS_W+1:0] w_diff;

    assign w_diff = {1'b0, r_p, r_q[DIVIDEND_W-1]} - {2'b00, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctrl.load) begin
            r_cnt <= i_count;
        end else if (i_ctrl.step && r_cnt != '0) begin
            r_cnt <= r_cnt - t_step'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_q <= i_dividend;
            r_p <= '0;
            r_d <= i_divisor;
        end else if (i_ctrl.step) begin
            r_q <= {r_q[DIVIDEND_W-2:0], ~w_diff[CENTS_W+1]};
            if (!w_diff[CENTS_W+1]) begin
                r_p <= w_diff[CENTS_W-1:0];
            end else begin
                r_p <= {r_p[CENTS_W-2:0], r_q[DIVIDEND_W-1]};
            end
        end
    end

    assign o_quotient    = r_q;
    assign o_remainder   = r_p;
    assign o_stat.cnt_nz = (r_cnt != '0);

endmodule

`default_nettype wire
